>>> hw/rtl/scti_pkg.sv
// ----------------------------------------------------------------------------
// Calibration table package
// Shared sizes, opcodes and cell interface types.
// ----------------------------------------------------------------------------
package scti_pkg;

   localparam int MaxPoints = 16;
   localparam int CntW      = $clog2(MaxPoints + 1);
   localparam int IdxW      = $clog2(MaxPoints);

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_INSERT  = 2'd1,
      OP_CONVERT = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // control broadcast to every cell
   typedef struct packed {
      logic        clear;
      logic        insert;
      logic [31:0] key;
      logic [31:0] val;
   } cell_ctl_type;

   // what a cell hands to its right neighbour
   typedef struct packed {
      logic        valid;
      logic        ge;
      logic [31:0] key;
      logic [31:0] val;
   } cell_link_type;

endpackage

>>> hw/rtl/scti_cell.sv
// ----------------------------------------------------------------------------
// Calibration table cell
// Holds one point; takes the new point or its left neighbour's on insert.
// ----------------------------------------------------------------------------
module scti_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  scti_pkg::cell_ctl_type  ctl,
   input  scti_pkg::cell_link_type left,
   output scti_pkg::cell_link_type right
);

   logic        valid_ff, valid_in;
   logic [31:0] key_ff, key_in, val_ff, val_in;
   logic        ge;

   // new key stays after this entry when new >= stored
   assign ge = !valid_ff || !($signed(ctl.key) < $signed(key_ff));

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert && left.valid && !(valid_ff && ge)) begin
         // larger keys shift; of the empty cells only the first takes an entry
         valid_in = 1'b1;
         if (!left.ge) begin
            key_in = left.key;
            val_in = left.val;
         end else begin
            key_in = ctl.key;
            val_in = ctl.val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      val_ff <= val_in;
   end

   assign right.valid = valid_ff;
   assign right.ge    = valid_ff ? ge : 1'b1;
   assign right.key   = key_ff;
   assign right.val   = val_ff;

endmodule

>>> hw/rtl/scti_div.sv
// ----------------------------------------------------------------------------
// Interpolation divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module scti_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] q_ff, q_in;
   logic [33:0] r_ff, r_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [34:0] trial;

   assign trial = {r_ff, q_ff[63]} - {2'b0, divisor};

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = dividend; r_in = '0; cnt_in = 7'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[34]) begin
            r_in = trial[33:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[32:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

>>> hw/rtl/sorted_calibration_table_interp.sv
// ----------------------------------------------------------------------------
// Sorted calibration table with linear interpolation
//
//  channel | direction | ports
//  req_    | in        | opcode, measured_value, real_value, sample_invalid
//  rsp_    | out       | calibrated_value, result_invalid, insert_rejected,
//          |           | points_held
//
// Clear and insert shift the row of cells in parallel, and the response is
// offered on the next cycle. Convert scans one table index per cycle;
// end-point and exact matches respond straight after the scan.
// Interpolation adds a 32x32 multiply state and a restoring divide.
// One transaction at a time; the result register holds under rsp_ready low.
// Reset empties the table and the control; stored points need no reset.
// ----------------------------------------------------------------------------
module sorted_calibration_table_interp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_measured_value,
   input  logic [31:0] req_real_value,
   input  logic        req_sample_invalid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_calibrated_value,
   output logic        rsp_result_invalid,
   output logic        rsp_insert_rejected,
   output logic [4:0]  rsp_points_held
);

   localparam int N = scti_pkg::MaxPoints;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_MUL, S_DIV, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [scti_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [scti_pkg::IdxW-1:0] p_ff, p_in;
   logic [31:0] s_ff, s_in, out_ff, out_in;
   logic        inv_ff, inv_in, rej_ff, rej_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in, w_ff, w_in;
   logic signed [31:0] r0_ff, r0_in;
   logic [63:0] prod_ff, prod_in;
   logic        start_ff;
   logic        div_done;
   logic [63:0] quot;

   scti_pkg::cell_ctl_type  ctl;
   scti_pkg::cell_link_type link [N+1];

   // head of the row: always present, never shifted
   assign link[0] = '{valid: 1'b1, ge: 1'b1, key: '0, val: '0};

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         scti_cell u_cell (.clock(clock), .reset(reset), .ctl(ctl),
                           .left(link[g]), .right(link[g+1]));
      end
   endgenerate

   logic accept;
   logic full;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (cnt_ff == scti_pkg::CntW'(N));

   assign ctl.clear  = accept && (req_opcode == scti_pkg::OP_CLEAR);
   assign ctl.insert = accept && (req_opcode == scti_pkg::OP_INSERT) && !full;
   assign ctl.key    = req_measured_value;
   assign ctl.val    = req_real_value;

   // read taps
   logic [31:0] key_p, val_p, key_pm, val_pm, key0, val0, keyl, vall;
   logic [scti_pkg::IdxW-1:0] last;
   assign last   = scti_pkg::IdxW'(cnt_ff - 1'b1);
   assign key_p  = link[p_ff + 1].key;
   assign val_p  = link[p_ff + 1].val;
   assign key_pm = link[p_ff].key;
   assign val_pm = link[p_ff].val;
   assign key0   = link[1].key;
   assign val0   = link[1].val;
   assign keyl   = link[last + 1].key;
   assign vall   = link[last + 1].val;

   logic signed [32:0] dy_abs;
   assign dy_abs = dy_ff[32] ? -dy_ff : dy_ff;

   scti_div u_div (.clock(clock), .reset(reset), .start(start_ff),
                   .dividend(prod_ff), .divisor(w_ff[32:0]),
                   .done(div_done), .quotient(quot));

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; p_in = p_ff; s_in = s_ff;
      out_in = out_ff; inv_in = inv_ff; rej_in = rej_ff;
      dx_in = dx_ff; dy_in = dy_ff; w_in = w_ff; r0_in = r0_ff;
      prod_in = prod_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_in = '0; inv_in = 1'b0; rej_in = 1'b0;
               s_in = req_measured_value; p_in = scti_pkg::IdxW'(1);
               state_in = S_RESP;
               case (req_opcode)
                  scti_pkg::OP_CLEAR: cnt_in = '0;
                  scti_pkg::OP_INSERT: begin
                     if (full) rej_in = 1'b1;
                     else cnt_in = cnt_ff + 1'b1;
                  end
                  scti_pkg::OP_CONVERT: begin
                     if (req_sample_invalid) inv_in = 1'b1;
                     else if (cnt_ff == '0) out_in = req_measured_value;
                     else state_in = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if ($signed(s_ff) <= $signed(key0)) begin
               out_in = val0; state_in = S_RESP;
            end else if ($signed(s_ff) >= $signed(keyl)) begin
               out_in = vall; state_in = S_RESP;
            end else if (p_ff < last && $signed(s_ff) > $signed(key_p)) begin
               p_in = p_ff + 1'b1;
            end else if (s_ff == key_p) begin
               out_in = val_p; state_in = S_RESP;
            end else begin
               dx_in = $signed({s_ff[31], s_ff}) - $signed({key_pm[31], key_pm});
               w_in  = $signed({key_p[31], key_p}) - $signed({key_pm[31], key_pm});
               dy_in = $signed({val_p[31], val_p}) - $signed({val_pm[31], val_pm});
               r0_in = val_pm;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // both operands lie below 2^32 here
            prod_in = {32'd0, dx_ff[31:0]} * {32'd0, dy_abs[31:0]};
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               out_in = dy_ff[32] ? r0_ff - quot[31:0] : r0_ff + quot[31:0];
               state_in = S_RESP;
            end
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // start divider in the same cycle as the product lands
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; start_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in;
         start_ff <= (state_ff == S_MUL);
      end
      p_ff <= p_in; s_ff <= s_in; out_ff <= out_in; inv_ff <= inv_in;
      rej_ff <= rej_in; dx_ff <= dx_in; dy_ff <= dy_in; w_ff <= w_in;
      r0_ff <= r0_in; prod_ff <= prod_in;
   end

   assign rsp_valid            = (state_ff == S_RESP);
   assign rsp_calibrated_value = out_ff;
   assign rsp_result_invalid   = inv_ff;
   assign rsp_insert_rejected  = rej_ff;
   assign rsp_points_held      = 5'(cnt_ff);

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Calibration table testbench
// Drives clear, insert, convert and unused-opcode transactions with random
// idling on both channels and checks each response against a behavioural table model.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] value;
      logic        invalid;
      logic        rejected;
      logic [4:0]  held;
   } cal_result_type;

   class cal_scoreboard;
      logic signed [31:0] keys[scti_pkg::MaxPoints];
      logic signed [31:0] reals[scti_pkg::MaxPoints];
      int unsigned        count;
      cal_result_type     pending[$];
      int                 mismatches;
      int                 checked;
      int                 converts;
      int                 interps;

      function void clear_table();
         count = 0;
      endfunction

      function logic signed [31:0] map_sample(logic signed [31:0] s);
         int unsigned        p;
         logic signed [63:0] k0, k1, r0, r1, dy, dx, w;
         logic [127:0]       prod;
         logic [127:0]       mag;
         p = 1;
         if (count == 0) return s;
         if (s <= keys[0]) return reals[0];
         if (s >= keys[count-1]) return reals[count-1];
         while (p < count - 1 && s > keys[p]) p++;
         if (s == keys[p]) return reals[p];
         interps++;
         k0 = keys[p-1];
         k1 = keys[p];
         r0 = reals[p-1];
         r1 = reals[p];
         dx = s - k0;
         w  = k1 - k0;
         dy = r1 - r0;
         prod = 128'(dx) * 128'(dy < 0 ? -dy : dy);
         mag  = prod / 128'(w);
         return dy < 0 ? 32'(r0 - 64'(mag)) : 32'(r0 + 64'(mag));
      endfunction

      function void note_request(scti_pkg::op_type op, logic signed [31:0] mv,
                                 logic signed [31:0] rv, logic bad);
         cal_result_type r;
         int unsigned    pos;
         r = '0;
         case (op)
            scti_pkg::OP_CLEAR: clear_table();
            scti_pkg::OP_INSERT: begin
               if (count >= scti_pkg::MaxPoints) begin
                  r.rejected = 1'b1;
               end else begin
                  pos = 0;
                  while (pos < count && !(mv < keys[pos])) pos++;
                  for (int j = count; j > pos; j--) begin
                     keys[j]  = keys[j-1];
                     reals[j] = reals[j-1];
                  end
                  keys[pos]  = mv;
                  reals[pos] = rv;
                  count++;
               end
            end
            scti_pkg::OP_CONVERT: begin
               converts++;
               if (bad) r.invalid = 1'b1;
               else r.value = map_sample(mv);
            end
            default: ;
         endcase
         r.held = 5'(count);
         pending.push_back(r);
      endfunction

      function void check_response(cal_result_type got);
         cal_result_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = scti_pkg::OP_CLEAR;
   logic [31:0] req_measured_value = '0;
   logic [31:0] req_real_value = '0;
   logic        req_sample_invalid = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_calibrated_value;
   logic        rsp_result_invalid;
   logic        rsp_insert_rejected;
   logic [4:0]  rsp_points_held;

   cal_scoreboard board = new();
   bit            stim_done = 0;
   int            stall_left = 0;

   always #5 clock = ~clock;

   sorted_calibration_table_interp dut (.*);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send(scti_pkg::op_type op, logic [31:0] mv, logic [31:0] rv,
                       logic bad);
      int gap;
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_measured_value <= mv;
      req_real_value     <= rv;
      req_sample_invalid <= bad;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(op, mv, rv, bad);
      gap = gap_length();
      // back to back: leave valid high for the next transaction
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 64)) - 32) <<< 16;
         default: return $urandom;
      endcase
   endfunction

   // random response stalls, now and then a long one
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(10, 60);
      end else if ($urandom_range(0, 99) < 8) begin
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 60) begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response({rsp_calibrated_value, rsp_result_invalid,
                               rsp_insert_rejected, rsp_points_held});
   end

   initial begin
      int fill;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, full table, duplicates, odd opcode
      send(scti_pkg::OP_CONVERT, 32'h8000_0000, '0, 1'b0);
      send(scti_pkg::OP_CONVERT, 32'h7fff_ffff, '1, 1'b1);
      send(scti_pkg::OP_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
      send(scti_pkg::OP_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send(scti_pkg::OP_CONVERT, 32'h0000_0000, '0, 1'b0);
      send(scti_pkg::OP_CONVERT, 32'h8000_0000, '0, 1'b0);
      send(scti_pkg::OP_CONVERT, 32'h7fff_ffff, '0, 1'b0);
      send(scti_pkg::OP_INSERT, 32'h0001_0000, 32'h0005_0000, 1'b0);
      send(scti_pkg::OP_INSERT, 32'h0001_0000, 32'h0009_0000, 1'b0);
      send(scti_pkg::OP_CONVERT, 32'h0001_0000, '0, 1'b0);
      send(scti_pkg::OP_CONVERT, 32'h0000_8000, '0, 1'b0);
      send(scti_pkg::OP_NONE, '1, '1, 1'b1);
      for (int i = 0; i < 14; i++) send(scti_pkg::OP_INSERT, $urandom, $urandom, 1'b0);
      send(scti_pkg::OP_INSERT, '0, '0, 1'b0);
      send(scti_pkg::OP_CONVERT, $urandom, '0, 1'b0);
      send(scti_pkg::OP_CLEAR, '1, '1, 1'b1);

      // random: fill a table, then mostly converts
      for (int n = 0; n < 1600; n++) begin
         if ($urandom_range(0, 99) < 3) begin
            send(scti_pkg::OP_CLEAR, $urandom, $urandom, 1'($urandom));
            fill = $urandom_range(0, 17);
            for (int i = 0; i < fill; i++)
               send(scti_pkg::OP_INSERT, rand_word(), rand_word(), 1'($urandom));
         end else if ($urandom_range(0, 99) < 2) begin
            send(scti_pkg::OP_NONE, $urandom, $urandom, 1'($urandom));
         end else if ($urandom_range(0, 99) < 10) begin
            send(scti_pkg::OP_INSERT, rand_word(), rand_word(), 1'($urandom));
         end else begin
            send(scti_pkg::OP_CONVERT, rand_word(), $urandom, $urandom_range(0, 9) == 0);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d responses, %0d converts, %0d interpolations",
               board.checked, board.converts, board.interps);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout waiting for responses");
      $display("testbench: done, errors");
      $finish;
   end
endmodule

>>> files.f
hw/rtl/scti_pkg.sv
hw/rtl/scti_cell.sv
hw/rtl/scti_div.sv
hw/rtl/sorted_calibration_table_interp.sv
tb/testbench.sv
